FILE: rtl/wcs_pkg.sv
// wcs_pkg: shared types and constants for the weighted category sampler.
// Used by the front queue, the search back end and the top level.
// No dependencies.
package wcs_pkg;

  localparam int DRAW_W  = 16;  // draw / raw item value width (Q0.16)
  localparam int CAT_W   = 9;   // width of the reported category
  localparam int QDEPTH  = 2;   // command queue depth
  localparam int QPTR_W  = 1;
  localparam int QFILL_W = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DRAW_W-1:0] value;
    logic              last;
  } cmd_t;

endpackage

FILE: rtl/wcs_ram.sv
// wcs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/wcs_front.sv
// wcs_front: accepts transactions, decodes them into commands and queues them
// for the back end. Depends on wcs_pkg.
module wcs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      in_func,
  input  logic [wcs_pkg::DRAW_W-1:0] in_item_value,
  input  logic                      in_is_last,
  output logic                      busy,
  output logic                      cmd_valid,
  output wcs_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);

  wcs_pkg::cmd_t                q_r [wcs_pkg::QDEPTH];
  logic [wcs_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wcs_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wcs_pkg::QFILL_W-1:0]  fill_r, fill_nxt;
  logic                         push;
  logic                         pop;
  wcs_pkg::cmd_t                new_cmd;

  assign busy      = (fill_r == wcs_pkg::QFILL_W'(wcs_pkg::QDEPTH));
  assign cmd_valid = (fill_r != '0);
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.op    = in_func ? wcs_pkg::OP_DRAW : wcs_pkg::OP_LOAD;
    new_cmd.value = in_item_value;
    new_cmd.last  = in_is_last;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: rtl/wcs_back.sv
// wcs_back: executes queued commands. Loads build the prefix-sum table, draws
// run a binary search over it. Depends on wcs_pkg and wcs_ram.
module wcs_back #(
  parameter int MAX_CATEGORIES = 256,
  parameter int WEIGHT_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  wcs_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  output logic [wcs_pkg::CAT_W-1:0]   out_category,
  output logic                        out_beyond_range
);

  localparam int AW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int CW = $clog2(MAX_CATEGORIES + 1);
  localparam int PW = WEIGHT_BITS + AW;
  localparam int XW = PW + wcs_pkg::DRAW_W;
  localparam logic [PW-1:0] WMASK = PW'((64'd1 << WEIGHT_BITS) - 64'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [PW-1:0]               total_r, total_nxt;
  logic                        ready_r, ready_nxt;
  logic [CW-1:0]               lo_r, lo_nxt;
  logic [CW-1:0]               hi_r, hi_nxt;
  logic [CW-1:0]               mid_r, mid_nxt;
  logic [wcs_pkg::DRAW_W-1:0]  draw_r, draw_nxt;
  logic                        last_r, last_nxt;
  logic [XW-1:0]               target_r, target_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [wcs_pkg::CAT_W-1:0]   out_cat_r, out_cat_nxt;
  logic                        out_beyond_r, out_beyond_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [PW-1:0]               ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [PW-1:0]               ram_rdata;

  logic [PW-1:0]               weight;
  logic [PW-1:0]               total_eff;
  logic                        hit;
  logic [CW-1:0]               lo_step, hi_step;
  logic [CW+wcs_pkg::CAT_W-1:0] cat_wide;

  wcs_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_CATEGORIES)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_pop   = (state_r == S_IDLE);
  assign weight    = PW'(cmd.value) & WMASK;
  assign total_eff = (total_r == '0) ? PW'(1) : total_r;
  // prefix * 2^16 >= draw * total
  assign hit       = {ram_rdata, {wcs_pkg::DRAW_W{1'b0}}} >= target_r;
  assign lo_step   = hit ? lo_r : mid_r + 1'b1;
  assign hi_step   = hit ? mid_r : hi_r;
  assign cat_wide  = {{wcs_pkg::CAT_W{1'b0}}, lo_r} + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    ready_nxt      = ready_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    draw_nxt       = draw_r;
    last_nxt       = last_r;
    target_nxt     = target_r;
    out_valid_nxt  = 1'b0;
    out_cat_nxt    = out_cat_r;
    out_beyond_nxt = out_beyond_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = total_r + weight;
    ram_re         = 1'b0;
    ram_raddr      = mid_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == wcs_pkg::OP_LOAD) begin
            if (!ready_r) begin
              if (count_r < CW'(MAX_CATEGORIES)) begin
                total_nxt = total_r + weight;
                count_nxt = count_r + 1'b1;
                ram_we    = 1'b1;
              end
              if (cmd.last) begin
                ready_nxt = 1'b1;
              end
            end
          end else if (ready_r) begin
            draw_nxt  = cmd.value;
            last_nxt  = cmd.last;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        target_nxt = XW'(draw_r) * XW'(total_eff);
        lo_nxt     = '0;
        hi_nxt     = count_r;
        mid_nxt    = count_r >> 1;
        if (count_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = mid_nxt[AW-1:0];
          state_nxt = S_SRCH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH: begin
        lo_nxt  = lo_step;
        hi_nxt  = hi_step;
        mid_nxt = lo_step + ((hi_step - lo_step) >> 1);
        if (lo_step < hi_step) begin
          ram_re    = 1'b1;
          ram_raddr = mid_nxt[AW-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_cat_nxt    = cat_wide[wcs_pkg::CAT_W-1:0];
        out_beyond_nxt = (lo_r >= count_r);
        if (last_r) begin
          count_nxt = '0;
          total_nxt = '0;
          ready_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    draw_r       <= draw_nxt;
    last_r       <= last_nxt;
    target_r     <= target_nxt;
    out_cat_r    <= out_cat_nxt;
    out_beyond_r <= out_beyond_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_category     = out_cat_r;
  assign out_beyond_range = out_beyond_r;

endmodule

FILE: rtl/weighted_category_sampler.sv
// Inverse-CDF categorical sampler: loads weights into a prefix-sum table, then
// maps Q0.16 draws to categories by binary search over the table memory.
// A load is consumed in the idle state; a draw runs the multiply, search and done
// states, one prefix-memory read per search step, and holds off the next command.
// A 2-entry command queue decouples start/busy from the search; results strobe
// out_valid for one cycle. Synchronous active-low reset empties queue and table.
module weighted_category_sampler #(
  parameter int MAX_CATEGORIES = 256,
  parameter int WEIGHT_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [wcs_pkg::DRAW_W-1:0]  in_item_value,
  input  logic                        in_is_last,
  output logic                        out_valid,
  output logic [wcs_pkg::CAT_W-1:0]   out_category,
  output logic                        out_beyond_range
);

  logic          cmd_valid;
  logic          cmd_pop;
  wcs_pkg::cmd_t cmd;

  wcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_func       (in_func),
    .in_item_value (in_item_value),
    .in_is_last    (in_is_last),
    .busy          (busy),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  wcs_back #(
    .MAX_CATEGORIES (MAX_CATEGORIES),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_category     (out_category),
    .out_beyond_range (out_beyond_range)
  );

endmodule

FILE: rtl/wcs_checker.sv
// wcs_checker: port-level assertions for weighted_category_sampler, with bind.
// Depends only on the top level's ports.
module wcs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // results are never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !busy))
    else $error("outputs active right after reset");

  // queue fills only through an accepted transaction
  a_busy_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

endmodule

bind weighted_category_sampler wcs_checker u_wcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: verif/weighted_category_sampler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_category_sampler: loads weight sets, issues
// Q0.16 draws and checks each category against an in-bench inverse-CDF predictor.
// Depends on rtl/wcs_pkg.sv and rtl/weighted_category_sampler.sv.
module weighted_category_sampler_test;

  localparam int TABLE_DEPTH = 256;
  localparam int ITEM_TARGET = 1150;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_TIME  = 40;

  typedef struct {
    logic [wcs_pkg::CAT_W-1:0] category;
    logic                      beyond;
  } pick_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_func;
  logic [wcs_pkg::DRAW_W-1:0] in_item_value;
  logic                       in_is_last;
  logic                       out_valid;
  logic [wcs_pkg::CAT_W-1:0]  out_category;
  logic                       out_beyond_range;

  // predictor state
  logic [23:0] tbl_prefix [TABLE_DEPTH];
  logic [8:0]  tbl_count;
  logic [23:0] tbl_total;
  logic        tbl_ready;

  pick_t exp_picks [$];
  int    err_count;
  int    items_sent;
  int    n_loads, n_answers, n_beyond, n_ignored;
  int    idle_cycles = 0;
  bit    burst_mode;

  weighted_category_sampler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_item_value    (in_item_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_category     (out_category),
    .out_beyond_range (out_beyond_range)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // First index whose scaled prefix reaches draw * total (lower bound).
  function automatic int lookup_category(input logic [15:0] draw);
    logic [63:0] target;
    logic [63:0] scaled;
    int lo, hi, mid;
    target = 64'(draw) * 64'((tbl_total == 0) ? 24'd1 : tbl_total);
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      scaled = 64'(tbl_prefix[8'(mid)]) << 16;
      if (scaled >= target) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // Updates the predicted table for one accepted transaction; returns 0 if ignored.
  function automatic bit apply_item(input logic func, input logic [15:0] val,
                                    input logic last);
    pick_t p;
    int    idx;
    if (func == wcs_pkg::OP_LOAD) begin
      if (tbl_ready) return 1'b0;
      if (tbl_count < TABLE_DEPTH) begin
        tbl_total = tbl_total + 24'(val);
        tbl_prefix[tbl_count[7:0]] = tbl_total;
        tbl_count = tbl_count + 9'd1;
        n_loads++;
      end
      if (last) tbl_ready = 1'b1;
      return 1'b1;
    end
    if (!tbl_ready) return 1'b0;
    idx = lookup_category(val);
    p.category = wcs_pkg::CAT_W'(idx + 1);
    p.beyond   = (idx >= tbl_count);
    exp_picks.push_back(p);
    n_answers++;
    if (p.beyond) n_beyond++;
    if (last) begin
      tbl_count = '0;
      tbl_total = '0;
      tbl_ready = 1'b0;
    end
    return 1'b1;
  endfunction

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_item(input logic func, input logic [15:0] val, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= func;
    in_item_value <= val;
    in_is_last    <= last;
    do @(posedge clk); while (busy);
    if (apply_item(func, val, last)) items_sent++;
    else n_ignored++;
  endtask

  function automatic logic [15:0] random_weight();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Draws cluster on and just below category boundaries to hit the equality case.
  function automatic logic [15:0] random_draw();
    logic [63:0] num, tot, d;
    int j;
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: begin
        if (tbl_count == 0) return 16'($urandom_range(0, 65535));
        j   = $urandom_range(0, tbl_count - 1);
        tot = 64'((tbl_total == 0) ? 24'd1 : tbl_total);
        num = 64'(tbl_prefix[8'(j)]) << 16;
        d   = (num + tot - 1) / tot;
        if ($urandom_range(0, 1) && d > 0) d = d - 1;
        if (d > 64'hFFFF) d = 64'hFFFF;
        return d[15:0];
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_basic_search();
    send_item(wcs_pkg::OP_LOAD, 16'd1, 1'b0);
    send_item(wcs_pkg::OP_LOAD, 16'd1, 1'b0);
    send_item(wcs_pkg::OP_LOAD, 16'd2, 1'b1);
    send_item(wcs_pkg::OP_DRAW, 16'd0, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd16384, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd16385, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd32768, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd32769, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'hFFFF, 1'b1);
  endtask

  task automatic test_extreme_weights();
    send_item(wcs_pkg::OP_LOAD, 16'hFFFF, 1'b0);
    send_item(wcs_pkg::OP_LOAD, 16'h0000, 1'b0);
    send_item(wcs_pkg::OP_LOAD, 16'hFFFF, 1'b1);
    send_item(wcs_pkg::OP_DRAW, 16'h8000, 1'b0);  // lands exactly on first prefix
    send_item(wcs_pkg::OP_DRAW, 16'h0000, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'hFFFF, 1'b1);
  endtask

  task automatic test_zero_total();
    send_item(wcs_pkg::OP_LOAD, 16'd0, 1'b0);
    send_item(wcs_pkg::OP_LOAD, 16'd0, 1'b1);
    send_item(wcs_pkg::OP_DRAW, 16'd0, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd1, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'hFFFF, 1'b1);
  endtask

  task automatic test_ignored_items();
    send_item(wcs_pkg::OP_DRAW, 16'd500, 1'b1);   // table not ready
    send_item(wcs_pkg::OP_LOAD, 16'd5, 1'b1);
    send_item(wcs_pkg::OP_LOAD, 16'd7, 1'b1);     // table already ready
    send_item(wcs_pkg::OP_DRAW, 16'd100, 1'b1);
  endtask

  task automatic test_full_table();
    burst_mode = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(wcs_pkg::OP_LOAD, random_weight(), 1'b0);
    burst_mode = 1'b0;
    send_item(wcs_pkg::OP_LOAD, random_weight(), 1'b0);  // dropped
    send_item(wcs_pkg::OP_LOAD, random_weight(), 1'b1);  // dropped, still marks ready
    for (int k = 0; k < 4; k++) send_item(wcs_pkg::OP_DRAW, random_draw(), k == 3);
    // all-zero full table: nonzero draw reports count+1
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      burst_mode = (i % 64) < 40;
      send_item(wcs_pkg::OP_LOAD, 16'd0, i == TABLE_DEPTH - 1);
    end
    burst_mode = 1'b0;
    send_item(wcs_pkg::OP_DRAW, 16'd1, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'hFFFF, 1'b0);
    send_item(wcs_pkg::OP_DRAW, 16'd0, 1'b1);
  endtask

  task automatic test_random_sets();
    int n, r, ndraws;
    while (items_sent < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 64)
                                                     : $urandom_range(65, 255);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(wcs_pkg::OP_DRAW, 16'($urandom), 1'($urandom));
        send_item(wcs_pkg::OP_LOAD, random_weight(),
                  (i == n - 1) && ($urandom_range(0, 19) != 0));
      end
      if (tbl_ready) begin
        ndraws = $urandom_range(1, 6);
        for (int k = 0; k < ndraws; k++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(wcs_pkg::OP_LOAD, random_weight(), 1'($urandom));
          send_item(wcs_pkg::OP_DRAW, random_draw(),
                    (k == ndraws - 1) && ($urandom_range(0, 19) != 0));
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    pick_t p;
    if (rst_n && out_valid) begin
      if (exp_picks.size() == 0) begin
        report_mismatch($sformatf("result cat=%0d with no pending draw", out_category));
      end else begin
        p = exp_picks.pop_front();
        if (out_category !== p.category)
          report_mismatch($sformatf("category got %0d exp %0d", out_category, p.category));
        if (out_beyond_range !== p.beyond)
          report_mismatch($sformatf("beyond_range got %b exp %b (cat %0d)",
                                    out_beyond_range, p.beyond, p.category));
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog expired with %0d results pending", exp_picks.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_func       <= wcs_pkg::OP_LOAD;
    in_item_value <= '0;
    in_is_last    <= 1'b0;
    err_count     = 0;
    items_sent    = 0;
    n_loads       = 0;
    n_answers     = 0;
    n_beyond      = 0;
    n_ignored     = 0;
    burst_mode    = 1'b0;
    tbl_count     = '0;
    tbl_total     = '0;
    tbl_ready     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_search();
    test_extreme_weights();
    test_zero_total();
    test_ignored_items();
    test_full_table();
    test_random_sets();

    start <= 1'b0;
    while (exp_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_TIME) @(posedge clk);

    $display("Covered %0d transactions: %0d weights stored, %0d draws answered",
             items_sent, n_loads, n_answers);
    $display("  %0d answers beyond range, %0d transactions ignored by the block",
             n_beyond, n_ignored);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
